// ===== rtl/core/lmj_pkg.sv =====
package lmj_pkg;

   localparam int MAX_SAMPLES = 64;
   localparam int IDX_W       = 6;
   localparam int CNT_W       = 7;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_DEPTH = 2 ** QUEUE_PTR_W;

   localparam logic signed [47:0] S48_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] S48_MIN = 48'sh8000_0000_0000;
   localparam logic [47:0]        U48_MAX = 48'hFFFF_FFFF_FFFF;
   localparam logic signed [47:0] ONE_Q24 = 48'sd16777216;

   typedef enum logic [1:0] {
      CSR_AMPLITUDE    = 2'd0,
      CSR_CENTER       = 2'd1,
      CSR_WIDTH_SQUARE = 2'd2,
      CSR_BASELINE     = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [47:0] amplitude;
      logic signed [47:0] center;
      logic signed [47:0] width_square;
      logic signed [47:0] baseline;
   } cfg_type;

   typedef struct packed {
      logic signed [47:0] position;
      logic               store;
      logic               final_sample;
   } item_type;

   typedef struct packed {
      logic               start;
      logic               narrow;
      logic signed [48:0] a;
      logic signed [48:0] b;
   } mul_req_type;

   typedef struct packed {
      logic        start;
      logic [47:0] divisor;
   } div_req_type;

   function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
      logic signed [47:0] r;
      if (v > 50'(S48_MAX)) r = S48_MAX;
      else if (v < 50'(S48_MIN)) r = S48_MIN;
      else r = v[47:0];
      return r;
   endfunction

   function automatic logic [47:0] mag49(input logic signed [48:0] v);
      logic signed [48:0] n;
      n = -v;
      return v[48] ? n[47:0] : v[47:0];
   endfunction

endpackage

// ===== rtl/core/lmj_queue.sv =====
module lmj_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lmj_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output lmj_pkg::item_type pop_item
);

   lmj_pkg::item_type                  entry_ff [lmj_pkg::QUEUE_DEPTH];
   logic [lmj_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [lmj_pkg::QUEUE_PTR_W:0]      fill_ff, fill_in;

   assign full      = (fill_ff == (lmj_pkg::QUEUE_PTR_W+1)'(lmj_pkg::QUEUE_DEPTH));
   assign not_empty = (fill_ff != '0);
   assign pop_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      fill_in = fill_ff;
      if (push && !pop) fill_in = fill_ff + 1'b1;
      else if (pop && !push) fill_in = fill_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_item;
   end

endmodule

// ===== rtl/core/lmj_front.sv =====
module lmj_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [47:0]       req_position,
   input  logic                     req_final_sample,
   input  logic                     full,
   output logic                     push,
   output lmj_pkg::item_type        item
);

   logic [lmj_pkg::CNT_W-1:0] count_ff, count_in;
   logic                      store;

   assign req_ready         = !full;
   assign push              = req_valid && !full;
   assign store             = (count_ff < lmj_pkg::CNT_W'(lmj_pkg::MAX_SAMPLES));
   assign item.position     = req_position;
   assign item.store        = store;
   assign item.final_sample = req_final_sample;

   always_comb begin
      count_in = count_ff;
      if (push) begin
         if (req_final_sample) count_in = '0;
         else if (store) count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else count_ff <= count_in;
   end

endmodule

// ===== rtl/core/lmj_mul.sv =====
module lmj_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  lmj_pkg::mul_req_type req,
   output logic                 done,
   output logic signed [47:0]   result
);

   typedef enum logic [2:0] {
      MUL_IDLE = 3'b001,
      MUL_ACC  = 3'b010,
      MUL_FIN  = 3'b100
   } mul_state_type;

   localparam logic [77:0]        LIM_WIDE   = 78'd140737488355328;
   localparam logic [77:0]        LIM_NARROW = 78'd2147483648;
   localparam logic signed [47:0] N32_MIN    = 48'shFFFF_8000_0000;
   localparam logic signed [47:0] N32_MAX    = 48'sh0000_7FFF_FFFF;

   mul_state_type      state_ff, state_in;
   logic [1:0]         step_ff;
   logic [47:0]        ua_ff, ub_ff;
   logic               neg_ff, narrow_ff;
   logic [95:0]        acc_ff, acc_in;
   logic               done_ff;
   logic signed [47:0] result_ff, res;
   logic [23:0]        pa, pb;
   logic [47:0]        pp;
   logic [77:0]        q, lim;
   logic [47:0]        qneg;

   assign done   = done_ff;
   assign result = result_ff;

   always_comb begin
      pa = step_ff[1] ? ua_ff[47:24] : ua_ff[23:0];
      pb = step_ff[0] ? ub_ff[47:24] : ub_ff[23:0];
      pp = pa * pb;
      case (step_ff)
         2'd0:    acc_in = acc_ff + 96'(pp);
         2'd3:    acc_in = acc_ff + (96'(pp) << 48);
         default: acc_in = acc_ff + (96'(pp) << 24);
      endcase
      q    = narrow_ff ? 78'(acc_ff >> 18) : 78'(acc_ff >> 24);
      lim  = narrow_ff ? LIM_NARROW : LIM_WIDE;
      qneg = 48'(0) - q[47:0];
      if (neg_ff) begin
         if (q > lim) res = narrow_ff ? N32_MIN : lmj_pkg::S48_MIN;
         else res = qneg;
      end else begin
         if (q > lim - 78'd1) res = narrow_ff ? N32_MAX : lmj_pkg::S48_MAX;
         else res = q[47:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         MUL_IDLE: if (req.start) state_in = MUL_ACC;
         MUL_ACC:  if (step_ff == 2'd3) state_in = MUL_FIN;
         MUL_FIN:  state_in = MUL_IDLE;
         default:  state_in = MUL_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MUL_IDLE;
         done_ff  <= 1'b0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= (state_ff == MUL_FIN);
         if (state_ff == MUL_ACC) step_ff <= step_ff + 1'b1;
         else step_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == MUL_IDLE && req.start) begin
         ua_ff     <= lmj_pkg::mag49(req.a);
         ub_ff     <= lmj_pkg::mag49(req.b);
         neg_ff    <= req.a[48] != req.b[48];
         narrow_ff <= req.narrow;
         acc_ff    <= '0;
      end else if (state_ff == MUL_ACC) begin
         acc_ff <= acc_in;
      end
      if (state_ff == MUL_FIN) result_ff <= res;
   end

endmodule

// ===== rtl/core/lmj_div.sv =====
module lmj_div (
   input  logic                 clock,
   input  logic                 reset,
   input  lmj_pkg::div_req_type req,
   output logic                 done,
   output logic [48:0]          quotient
);

   localparam logic [5:0] DIV_TOP = 6'd48;

   logic        busy_ff, done_ff;
   logic [5:0]  bit_ff;
   logic [47:0] rem_ff, divisor_ff;
   logic [48:0] quot_ff;
   logic [48:0] shifted, diff;
   logic        qbit;

   assign done     = done_ff;
   assign quotient = quot_ff;

   always_comb begin
      shifted = {rem_ff, bit_ff == DIV_TOP};
      diff    = shifted - {1'b0, divisor_ff};
      qbit    = (shifted >= {1'b0, divisor_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (!busy_ff && req.start) busy_ff <= 1'b1;
         else if (busy_ff && bit_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!busy_ff && req.start) begin
         bit_ff     <= DIV_TOP;
         rem_ff     <= '0;
         quot_ff    <= '0;
         divisor_ff <= req.divisor;
      end else if (busy_ff) begin
         bit_ff  <= bit_ff - 1'b1;
         rem_ff  <= qbit ? diff[47:0] : shifted[47:0];
         quot_ff <= {quot_ff[47:0], qbit};
      end
   end

endmodule

// ===== rtl/core/lmj_back.sv =====
module lmj_back (
   input  logic                    clock,
   input  logic                    reset,
   input  lmj_pkg::cfg_type        cfg,
   input  logic                    q_valid,
   input  lmj_pkg::item_type       q_item,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [5:0]              rsp_sample_index,
   output logic signed [47:0]      rsp_model_value,
   output logic signed [31:0]      rsp_grad_amplitude,
   output logic signed [31:0]      rsp_grad_center,
   output logic signed [31:0]      rsp_grad_width,
   output logic [47:0]             rsp_weight_amplitude,
   output logic [47:0]             rsp_weight_center,
   output logic [47:0]             rsp_weight_width,
   output logic                    rsp_degenerate,
   output logic                    rsp_last
);

   typedef enum logic [11:0] {
      ST_IDLE   = 12'b0000_0000_0001,
      ST_AG     = 12'b0000_0000_0010,
      ST_READ   = 12'b0000_0000_0100,
      ST_LOAD   = 12'b0000_0000_1000,
      ST_DD     = 12'b0000_0001_0000,
      ST_RECIP  = 12'b0000_0010_0000,
      ST_CHAIN  = 12'b0000_0100_0000,
      ST_STORE  = 12'b0000_1000_0000,
      ST_WEIGHT = 12'b0001_0000_0000,
      ST_READ2  = 12'b0010_0000_0000,
      ST_SCALE  = 12'b0100_0000_0000,
      ST_EMIT   = 12'b1000_0000_0000
   } state_type;

   state_type                 state_ff, state_in;
   logic                      issue_ff, issue_in;
   logic [2:0]                step_ff, step_in;
   logic [lmj_pkg::CNT_W-1:0] wr_n_ff, wr_n_in, cnt_ff, cnt_in, n_ff, n_in;
   logic signed [47:0]        ag_ff, ag_in, d_ff, d_in, den_ff, den_in, dv_ff, dv_in;
   logic signed [47:0]        tmp_ff, tmp_in, g0_ff, g0_in, g1_ff, g1_in, g2_ff, g2_in;
   logic signed [47:0]        model_ff, model_in;
   logic [47:0]               max_ff [3];
   logic [47:0]               max_in [3];
   logic [47:0]               w_ff [3];
   logic [47:0]               w_in [3];
   logic [47:0]               gmag [3];
   logic                      degen_ff, degen_in;
   logic                      rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [5:0]                rsp_index_ff, rsp_index_in;
   logic signed [47:0]        rsp_model_ff, rsp_model_in;
   logic signed [31:0]        rsp_grad_ff [3];
   logic signed [31:0]        rsp_grad_in [3];

   logic signed [47:0]        sample_mem [lmj_pkg::MAX_SAMPLES];
   logic [191:0]              res_mem [lmj_pkg::MAX_SAMPLES];
   logic signed [47:0]        sample_q;
   logic [191:0]              res_q;
   logic                      smem_we, rmem_we;

   lmj_pkg::mul_req_type      mul_req;
   lmj_pkg::div_req_type      div_req;
   logic                      mul_done, div_done;
   logic signed [47:0]        mul_res;
   logic [48:0]               div_quot;

   logic [1:0]                c;
   logic signed [47:0]        one_minus, den_v, grad_sel;
   logic                      last_n;

   lmj_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .req    (mul_req),
      .done   (mul_done),
      .result (mul_res)
   );

   lmj_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign c         = step_ff[1:0];
   assign one_minus = lmj_pkg::sat48(50'(lmj_pkg::ONE_Q24) - 50'(g0_ff));
   assign den_v     = lmj_pkg::sat48(50'(mul_res) + 50'(cfg.width_square));
   assign last_n    = (n_ff + 1'b1 == cnt_ff);
   assign gmag[0]   = lmj_pkg::mag49(49'(g0_ff));
   assign gmag[1]   = lmj_pkg::mag49(49'(g1_ff));
   assign gmag[2]   = lmj_pkg::mag49(49'(g2_ff));

   always_comb begin
      case (c)
         2'd0:    grad_sel = res_q[143:96];
         2'd1:    grad_sel = res_q[95:48];
         default: grad_sel = res_q[47:0];
      endcase
   end

   always_comb begin
      mul_req.start  = issue_ff && (state_ff == ST_AG || state_ff == ST_DD ||
                                    state_ff == ST_CHAIN || state_ff == ST_SCALE);
      mul_req.narrow = (state_ff == ST_SCALE);
      mul_req.a      = 49'(cfg.amplitude);
      mul_req.b      = 49'(cfg.width_square);
      unique case (state_ff)
         ST_DD: begin
            mul_req.a = 49'(d_ff);
            mul_req.b = 49'(d_ff);
         end
         ST_CHAIN: begin
            case (step_ff)
               3'd0: begin
                  mul_req.a = 49'(cfg.width_square);
                  mul_req.b = 49'(dv_ff);
               end
               3'd1: begin
                  mul_req.a = 49'(ag_ff);
                  mul_req.b = 49'(d_ff);
               end
               3'd2, 3'd3: begin
                  mul_req.a = 49'(tmp_ff);
                  mul_req.b = 49'(dv_ff);
               end
               3'd4: begin
                  mul_req.a = 49'(cfg.amplitude);
                  mul_req.b = 49'(dv_ff);
               end
               3'd5: begin
                  mul_req.a = 49'(tmp_ff);
                  mul_req.b = 49'(one_minus);
               end
               default: begin
                  mul_req.a = 49'(ag_ff);
                  mul_req.b = 49'(dv_ff);
               end
            endcase
         end
         ST_SCALE: begin
            mul_req.a = 49'(grad_sel);
            mul_req.b = $signed({1'b0, w_ff[c]});
         end
         default: ;
      endcase
      div_req.start   = issue_ff && (state_ff == ST_RECIP ||
                                     (state_ff == ST_WEIGHT && max_ff[c] != '0));
      div_req.divisor = (state_ff == ST_WEIGHT) ? max_ff[c] : lmj_pkg::mag49(49'(den_ff));
   end

   always_comb begin
      state_in     = state_ff;
      issue_in     = issue_ff;
      step_in      = step_ff;
      wr_n_in      = wr_n_ff;
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      ag_in        = ag_ff;
      d_in         = d_ff;
      den_in       = den_ff;
      dv_in        = dv_ff;
      tmp_in       = tmp_ff;
      g0_in        = g0_ff;
      g1_in        = g1_ff;
      g2_in        = g2_ff;
      model_in     = model_ff;
      max_in       = max_ff;
      w_in         = w_ff;
      degen_in     = degen_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_index_in = rsp_index_ff;
      rsp_model_in = rsp_model_ff;
      rsp_grad_in  = rsp_grad_ff;
      q_pop        = 1'b0;
      smem_we      = 1'b0;
      rmem_we      = 1'b0;
      if (mul_req.start || div_req.start) issue_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_item.store) begin
                  smem_we = 1'b1;
                  wr_n_in = wr_n_ff + 1'b1;
               end
               if (q_item.final_sample) begin
                  cnt_in   = wr_n_ff + lmj_pkg::CNT_W'(q_item.store);
                  degen_in = 1'b0;
                  max_in   = '{default: '0};
                  issue_in = 1'b1;
                  state_in = ST_AG;
               end
            end
         end
         ST_AG: begin
            if (mul_done) begin
               ag_in    = mul_res;
               n_in     = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_LOAD;
         ST_LOAD: begin
            d_in     = lmj_pkg::sat48(50'(cfg.center) - 50'(sample_q));
            issue_in = 1'b1;
            state_in = ST_DD;
         end
         ST_DD: begin
            if (mul_done) begin
               den_in   = den_v;
               issue_in = 1'b1;
               if (den_v == '0) begin
                  dv_in    = lmj_pkg::S48_MAX;
                  degen_in = 1'b1;
                  step_in  = '0;
                  state_in = ST_CHAIN;
               end else begin
                  state_in = ST_RECIP;
               end
            end
         end
         ST_RECIP: begin
            if (div_done) begin
               if (!den_ff[47]) begin
                  if (div_quot[48] || div_quot[47]) begin
                     dv_in    = lmj_pkg::S48_MAX;
                     degen_in = 1'b1;
                  end else dv_in = div_quot[47:0];
               end else begin
                  if (div_quot[48] || (div_quot[47] && (|div_quot[46:0]))) begin
                     dv_in    = lmj_pkg::S48_MIN;
                     degen_in = 1'b1;
                  end else dv_in = 48'(0) - div_quot[47:0];
               end
               step_in  = '0;
               issue_in = 1'b1;
               state_in = ST_CHAIN;
            end
         end
         ST_CHAIN: begin
            if (mul_done) begin
               case (step_ff)
                  3'd0:    g0_in = mul_res;
                  3'd3:    g1_in = lmj_pkg::sat48(-(50'(mul_res) <<< 1));
                  3'd5:    g2_in = mul_res;
                  3'd6:    model_in = lmj_pkg::sat48(50'(cfg.baseline) + 50'(mul_res));
                  default: tmp_in = mul_res;
               endcase
               if (step_ff == 3'd6) state_in = ST_STORE;
               else begin
                  step_in  = step_ff + 1'b1;
                  issue_in = 1'b1;
               end
            end
         end
         ST_STORE: begin
            rmem_we = 1'b1;
            for (int i = 0; i < 3; i++) begin
               if (gmag[i] > max_ff[i]) max_in[i] = gmag[i];
            end
            if (last_n) begin
               step_in  = '0;
               issue_in = 1'b1;
               state_in = ST_WEIGHT;
            end else begin
               n_in     = n_ff + 1'b1;
               state_in = ST_READ;
            end
         end
         ST_WEIGHT: begin
            if ((issue_ff && max_ff[c] == '0) || div_done) begin
               if (div_done && !div_quot[48]) w_in[c] = div_quot[47:0];
               else begin
                  w_in[c]  = lmj_pkg::U48_MAX;
                  degen_in = 1'b1;
               end
               if (c == 2'd2) begin
                  n_in     = '0;
                  issue_in = 1'b0;
                  state_in = ST_READ2;
               end else begin
                  step_in  = step_ff + 1'b1;
                  issue_in = 1'b1;
               end
            end
         end
         ST_READ2: begin
            step_in  = '0;
            issue_in = 1'b1;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            if (mul_done) begin
               rsp_grad_in[c] = mul_res[31:0];
               if (c == 2'd2) begin
                  rsp_valid_in = 1'b1;
                  rsp_model_in = res_q[191:144];
                  rsp_index_in = n_ff[5:0];
                  rsp_last_in  = last_n;
                  state_in     = ST_EMIT;
               end else begin
                  step_in  = step_ff + 1'b1;
                  issue_in = 1'b1;
               end
            end
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  wr_n_in  = '0;
                  state_in = ST_IDLE;
               end else begin
                  n_in     = n_ff + 1'b1;
                  state_in = ST_READ2;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issue_ff     <= 1'b0;
         wr_n_ff      <= '0;
         max_ff       <= '{default: '0};
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         wr_n_ff      <= wr_n_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff      <= step_in;
      cnt_ff       <= cnt_in;
      n_ff         <= n_in;
      ag_ff        <= ag_in;
      d_ff         <= d_in;
      den_ff       <= den_in;
      dv_ff        <= dv_in;
      tmp_ff       <= tmp_in;
      g0_ff        <= g0_in;
      g1_ff        <= g1_in;
      g2_ff        <= g2_in;
      model_ff     <= model_in;
      w_ff         <= w_in;
      degen_ff     <= degen_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_index_ff <= rsp_index_in;
      rsp_model_ff <= rsp_model_in;
      rsp_grad_ff  <= rsp_grad_in;
   end

   always_ff @(posedge clock) begin
      if (smem_we) sample_mem[wr_n_ff[lmj_pkg::IDX_W-1:0]] <= q_item.position;
      sample_q <= sample_mem[n_ff[lmj_pkg::IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (rmem_we) res_mem[n_ff[lmj_pkg::IDX_W-1:0]] <= {model_ff, g0_ff, g1_ff, g2_ff};
      res_q <= res_mem[n_ff[lmj_pkg::IDX_W-1:0]];
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_sample_index     = rsp_index_ff;
   assign rsp_model_value      = rsp_model_ff;
   assign rsp_grad_amplitude   = rsp_grad_ff[0];
   assign rsp_grad_center      = rsp_grad_ff[1];
   assign rsp_grad_width       = rsp_grad_ff[2];
   assign rsp_weight_amplitude = w_ff[0];
   assign rsp_weight_center    = w_ff[1];
   assign rsp_weight_width     = w_ff[2];
   assign rsp_degenerate       = degen_ff;
   assign rsp_last             = rsp_last_ff;

endmodule

// ===== rtl/core/lorentzian_model_and_jacobian.sv =====
// channel   direction  handshake              payload
// req       in         req_valid/req_ready    position, final_sample
// rsp       out        rsp_valid/rsp_ready    index, model, grads, weights, flags
// csr       in         csr_write_enable       csr_index, csr_write_data
//
// A sample is accepted in the cycle it is offered while the two-entry queue has room.
// A run opens with one product. In the first pass each sample takes a product, a
// division (skipped on a zero denominator) and a chain of seven products; then each
// weight takes one division (none on a zero maximum), and each result three products.
// Synchronous active-high reset; no clearing pass. A stalled result holds
// its register and the back end; the front keeps filling the queue.
module lorentzian_model_and_jacobian (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [47:0] req_position,
   input  logic               req_final_sample,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [5:0]         rsp_sample_index,
   output logic signed [47:0] rsp_model_value,
   output logic signed [31:0] rsp_grad_amplitude,
   output logic signed [31:0] rsp_grad_center,
   output logic signed [31:0] rsp_grad_width,
   output logic [47:0]        rsp_weight_amplitude,
   output logic [47:0]        rsp_weight_center,
   output logic [47:0]        rsp_weight_width,
   output logic               rsp_degenerate,
   output logic               rsp_last,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [47:0]        csr_write_data
);

   lmj_pkg::cfg_type  cfg_ff;
   lmj_pkg::item_type push_item, pop_item;
   logic              push, pop, full, not_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (lmj_pkg::csr_index_type'(csr_index))
            lmj_pkg::CSR_AMPLITUDE:    cfg_ff.amplitude    <= csr_write_data;
            lmj_pkg::CSR_CENTER:       cfg_ff.center       <= csr_write_data;
            lmj_pkg::CSR_WIDTH_SQUARE: cfg_ff.width_square <= csr_write_data;
            lmj_pkg::CSR_BASELINE:     cfg_ff.baseline     <= csr_write_data;
            default: ;
         endcase
      end
   end

   lmj_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_position     (req_position),
      .req_final_sample (req_final_sample),
      .full             (full),
      .push             (push),
      .item             (push_item)
   );

   lmj_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .pop_item  (pop_item)
   );

   lmj_back u_back (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg_ff),
      .q_valid              (not_empty),
      .q_item               (pop_item),
      .q_pop                (pop),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_sample_index     (rsp_sample_index),
      .rsp_model_value      (rsp_model_value),
      .rsp_grad_amplitude   (rsp_grad_amplitude),
      .rsp_grad_center      (rsp_grad_center),
      .rsp_grad_width       (rsp_grad_width),
      .rsp_weight_amplitude (rsp_weight_amplitude),
      .rsp_weight_center    (rsp_weight_center),
      .rsp_weight_width     (rsp_weight_width),
      .rsp_degenerate       (rsp_degenerate),
      .rsp_last             (rsp_last)
   );

endmodule

// ===== tb/lorentzian_model_and_jacobian_test.sv =====
`timescale 1ns / 1ps

module lorentzian_model_and_jacobian_test;

   localparam longint Q48_HI = 64'sh7FFF_FFFF_FFFF;
   localparam longint Q48_LO = -Q48_HI - 1;
   localparam longint Q32_HI = 64'sh7FFF_FFFF;
   localparam longint Q32_LO = -Q32_HI - 1;
   localparam longint UNIT_Q24 = 64'sd16777216;
   localparam longint TWO_48 = 64'sd1 << 48;

   typedef struct {
      logic [5:0]         sample_index;
      logic signed [47:0] model_value;
      logic signed [31:0] grad_amplitude;
      logic signed [31:0] grad_center;
      logic signed [31:0] grad_width;
      logic [47:0]        weight_amplitude;
      logic [47:0]        weight_center;
      logic [47:0]        weight_width;
      logic               degenerate;
      logic               last;
   } profile_point_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [47:0] req_position;
   logic               req_final_sample;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [5:0]         rsp_sample_index;
   logic signed [47:0] rsp_model_value;
   logic signed [31:0] rsp_grad_amplitude;
   logic signed [31:0] rsp_grad_center;
   logic signed [31:0] rsp_grad_width;
   logic [47:0]        rsp_weight_amplitude;
   logic [47:0]        rsp_weight_center;
   logic [47:0]        rsp_weight_width;
   logic               rsp_degenerate;
   logic               rsp_last;
   logic               csr_write_enable;
   logic [1:0]         csr_index;
   logic [47:0]        csr_write_data;

   profile_point_type expected_points[$];
   longint line_amplitude, line_center, line_width_sq, line_baseline;
   longint held_positions[lmj_pkg::MAX_SAMPLES];
   int     held_count;
   int     error_count;
   int     send_idle_pct;
   int     recv_idle_pct;

   lorentzian_model_and_jacobian i_dut (.*);

   always #2 clock = ~clock;

   initial begin
      #10ms;
      $display("lorentzian_model_and_jacobian_test: errors");
      $finish;
   end

   function automatic longint clamp_q48(longint v);
      if (v > Q48_HI) return Q48_HI;
      if (v < Q48_LO) return Q48_LO;
      return v;
   endfunction

   function automatic longint mul_shift(longint a, longint b, int sh, longint lo, longint hi);
      logic [127:0] ua, ub, m;
      bit           neg;
      ua = 128'((a < 0) ? -a : a);
      ub = 128'((b < 0) ? -b : b);
      m = (ua * ub) >> sh;
      neg = (a < 0) != (b < 0);
      if (neg) begin
         if (m > 128'(-lo)) return lo;
         return -longint'(m);
      end
      if (m > 128'(hi)) return hi;
      return longint'(m);
   endfunction

   function automatic longint mul_q24(longint a, longint b);
      return mul_shift(a, b, 24, Q48_LO, Q48_HI);
   endfunction

   function automatic longint reciprocal_q24(longint den, ref bit degen);
      longint q;
      if (den == 0) begin
         degen = 1;
         return Q48_HI;
      end
      q = TWO_48 / ((den < 0) ? -den : den);
      if (den > 0) begin
         if (q > Q48_HI) begin
            degen = 1;
            return Q48_HI;
         end
         return q;
      end
      if (q > -Q48_LO) begin
         degen = 1;
         return Q48_LO;
      end
      return -q;
   endfunction

   task automatic predict_profile();
      longint model[lmj_pkg::MAX_SAMPLES];
      longint grads[lmj_pkg::MAX_SAMPLES][3];
      longint peak[3];
      longint weights[3];
      longint ag, d, den, dv, t, m;
      bit     degen;
      profile_point_type p;
      degen = 0;
      peak = '{0, 0, 0};
      ag = mul_q24(line_amplitude, line_width_sq);
      for (int n = 0; n < held_count; n++) begin
         d = clamp_q48(line_center - held_positions[n]);
         den = clamp_q48(mul_q24(d, d) + line_width_sq);
         dv = reciprocal_q24(den, degen);
         grads[n][0] = mul_q24(line_width_sq, dv);
         t = mul_q24(mul_q24(mul_q24(ag, d), dv), dv);
         grads[n][1] = clamp_q48(-2 * t);
         grads[n][2] = mul_q24(mul_q24(line_amplitude, dv),
                               clamp_q48(UNIT_Q24 - grads[n][0]));
         model[n] = clamp_q48(line_baseline + mul_q24(ag, dv));
         for (int c = 0; c < 3; c++) begin
            m = (grads[n][c] < 0) ? -grads[n][c] : grads[n][c];
            if (m > peak[c]) peak[c] = m;
         end
      end
      for (int c = 0; c < 3; c++) begin
         if (peak[c] == 0) begin
            weights[c] = TWO_48 - 1;
            degen = 1;
         end else begin
            weights[c] = TWO_48 / peak[c];
            if (weights[c] > TWO_48 - 1) begin
               weights[c] = TWO_48 - 1;
               degen = 1;
            end
         end
      end
      for (int n = 0; n < held_count; n++) begin
         p.sample_index = n[5:0];
         p.model_value = model[n][47:0];
         p.grad_amplitude = 32'(mul_shift(grads[n][0], weights[0], 18, Q32_LO, Q32_HI));
         p.grad_center = 32'(mul_shift(grads[n][1], weights[1], 18, Q32_LO, Q32_HI));
         p.grad_width = 32'(mul_shift(grads[n][2], weights[2], 18, Q32_LO, Q32_HI));
         p.weight_amplitude = weights[0][47:0];
         p.weight_center = weights[1][47:0];
         p.weight_width = weights[2][47:0];
         p.degenerate = degen;
         p.last = (n + 1 == held_count);
         expected_points.push_back(p);
      end
      held_count = 0;
   endtask

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0h want %0h", what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      profile_point_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_points.size() == 0) begin
            report_mismatch("unexpected request", longint'(rsp_sample_index), 0);
         end else begin
            e = expected_points.pop_front();
            if (rsp_sample_index !== e.sample_index)
               report_mismatch("sample_index", longint'(rsp_sample_index),
                               longint'(e.sample_index));
            if (rsp_model_value !== e.model_value)
               report_mismatch("model_value", longint'(rsp_model_value),
                               longint'(e.model_value));
            if (rsp_grad_amplitude !== e.grad_amplitude)
               report_mismatch("grad_amplitude", longint'(rsp_grad_amplitude),
                               longint'(e.grad_amplitude));
            if (rsp_grad_center !== e.grad_center)
               report_mismatch("grad_center", longint'(rsp_grad_center),
                               longint'(e.grad_center));
            if (rsp_grad_width !== e.grad_width)
               report_mismatch("grad_width", longint'(rsp_grad_width),
                               longint'(e.grad_width));
            if (rsp_weight_amplitude !== e.weight_amplitude)
               report_mismatch("weight_amplitude", longint'(rsp_weight_amplitude),
                               longint'(e.weight_amplitude));
            if (rsp_weight_center !== e.weight_center)
               report_mismatch("weight_center", longint'(rsp_weight_center),
                               longint'(e.weight_center));
            if (rsp_weight_width !== e.weight_width)
               report_mismatch("weight_width", longint'(rsp_weight_width),
                               longint'(e.weight_width));
            if (rsp_degenerate !== e.degenerate)
               report_mismatch("degenerate", longint'(rsp_degenerate),
                               longint'(e.degenerate));
            if (rsp_last !== e.last)
               report_mismatch("last", longint'(rsp_last), longint'(e.last));
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   function automatic longint rand_q48();
      logic [47:0] r;
      r = 48'({$urandom, $urandom});
      return longint'($signed(r));
   endfunction

   function automatic longint rand_near(longint base, int span);
      return clamp_q48(base + (rand_q48() >>> (47 - span)));
   endfunction

   task automatic send_sample(longint position, bit final_sample);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_position <= position[47:0];
      req_final_sample <= final_sample;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (held_count < lmj_pkg::MAX_SAMPLES) begin
         held_positions[held_count] = position;
         held_count++;
      end
      if (final_sample) predict_profile();
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_line(longint a, longint e, longint g, longint b);
      longint vals[4];
      lmj_pkg::csr_index_type regs[4];
      vals = '{a, e, g, b};
      regs = '{lmj_pkg::CSR_AMPLITUDE, lmj_pkg::CSR_CENTER, lmj_pkg::CSR_WIDTH_SQUARE,
               lmj_pkg::CSR_BASELINE};
      wait_idle();
      for (int i = 0; i < 4; i++) begin
         csr_write_enable <= 1'b1;
         csr_index <= regs[i];
         csr_write_data <= vals[i][47:0];
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
      @(posedge clock);
      line_amplitude = a;
      line_center = e;
      line_width_sq = g;
      line_baseline = b;
   endtask

   task automatic random_line();
      if ($urandom_range(3) == 0)
         write_line(rand_q48(), rand_q48(), rand_q48(), rand_q48());
      else
         write_line(rand_near(0, 28), rand_near(0, 30),
                    longint'($urandom_range(1 << 28, 1 << 20)), rand_near(0, 26));
   endtask

   task automatic test_reset_values();
      send_sample(0, 1'b0);
      send_sample(Q48_HI, 1'b0);
      send_sample(Q48_LO, 1'b1);
   endtask

   task automatic test_extremes();
      write_line(Q48_HI, Q48_LO, Q48_HI, Q48_HI);
      send_sample(Q48_HI, 1'b0);
      send_sample(Q48_LO, 1'b1);
      write_line(Q48_LO, Q48_HI, Q48_LO, Q48_LO);
      send_sample(Q48_LO, 1'b0);
      send_sample(0, 1'b1);
      // zero denominator and both division overflows
      write_line(UNIT_Q24, UNIT_Q24, 0, 0);
      send_sample(UNIT_Q24, 1'b1);
      write_line(UNIT_Q24, 0, 1, 0);
      send_sample(0, 1'b1);
      write_line(-UNIT_Q24, 0, -1, UNIT_Q24);
      send_sample(0, 1'b0);
      send_sample(UNIT_Q24, 1'b1);
      // one LSB column maximum
      write_line(0, 0, 1, 0);
      send_sample(11863283, 1'b1);
      write_line(5 * UNIT_Q24, 2 * UNIT_Q24, UNIT_Q24 / 4, -UNIT_Q24);
      for (int i = 0; i < 8; i++) send_sample(UNIT_Q24 * i / 2, i == 7);
   endtask

   task automatic test_store_full();
      for (int i = 0; i < 70; i++) send_sample(rand_near(2 * UNIT_Q24, 26), i == 69);
   endtask

   task automatic test_random_runs(int items, int s_idle, int r_idle);
      int sent, len;
      wait_idle();
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
      sent = 0;
      while (sent < items) begin
         random_line();
         len = ($urandom_range(19) == 0) ? $urandom_range(64, 1) : $urandom_range(8, 1);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(3) == 0) send_sample(rand_q48(), i == len - 1);
            else send_sample(rand_near(line_center, $urandom_range(30, 20)), i == len - 1);
         end
         sent += len;
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_position <= '0;
      req_final_sample <= 1'b0;
      rsp_ready <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_index <= lmj_pkg::CSR_AMPLITUDE;
      csr_write_data <= '0;
      line_amplitude = 0;
      line_center = 0;
      line_width_sq = 0;
      line_baseline = 0;
      held_count = 0;
      error_count = 0;
      send_idle_pct = 22;
      recv_idle_pct = 79;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_extremes();
      test_store_full();
      test_random_runs(90, 22, 79);
      test_random_runs(90, 79, 22);
      test_random_runs(90, 0, 0);
      wait_idle();
      if (error_count == 0)
         $display("lorentzian_model_and_jacobian_test: clean");
      else
         $display("lorentzian_model_and_jacobian_test: errors");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/lmj_pkg.sv
rtl/core/lmj_queue.sv
rtl/core/lmj_front.sv
rtl/core/lmj_mul.sv
rtl/core/lmj_div.sv
rtl/core/lmj_back.sv
rtl/core/lorentzian_model_and_jacobian.sv
tb/lorentzian_model_and_jacobian_test.sv
